// ===== src/gpmc_pkg.sv =====
// Shared types and constants for the gear PWM motor controller.
// Holds the beat structs, command and register codes, and the segment table.
// No dependencies.
package gpmc_pkg;

    // Event kinds carried by an input beat
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_KEY     = 2'd1,
        CMD_SERIAL  = 2'd2,
        CMD_MEASURE = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic [2:0] REG_PERIOD_TICKS = 3'd0;
    localparam logic [2:0] REG_GEAR1_DUTY   = 3'd1;
    localparam logic [2:0] REG_GEAR2_DUTY   = 3'd2;
    localparam logic [2:0] REG_GEAR3_DUTY   = 3'd3;
    localparam logic [2:0] REG_NEAR_THRESH  = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int DIST_W      = 14;

    // Reset values of the configuration registers
    localparam logic [7:0]        RST_PERIOD_TICKS = 8'd100;
    localparam logic [7:0]        RST_GEAR1_DUTY   = 8'd50;
    localparam logic [7:0]        RST_GEAR2_DUTY   = 8'd75;
    localparam logic [7:0]        RST_GEAR3_DUTY   = 8'd100;
    localparam logic [DIST_W-1:0] RST_NEAR_THRESH  = 14'd2;

    // Serial command bytes
    localparam logic [7:0] BYTE_GEAR3_ALT = 8'h34;
    localparam logic [7:0] BYTE_STOP      = 8'h35;
    localparam logic [7:0] BYTE_GEAR1     = 8'h36;
    localparam logic [7:0] BYTE_GEAR2     = 8'h37;
    localparam logic [7:0] BYTE_GEAR3     = 8'h38;

    // Gear codes
    localparam logic [1:0] GEAR_STOP = 2'd0;
    localparam logic [1:0] GEAR_ONE  = 2'd1;
    localparam logic [1:0] GEAR_TWO  = 2'd2;
    localparam logic [1:0] GEAR_THREE = 2'd3;

    // ticks*17/100 as (ticks*DIST_MULT) >> DIST_SHIFT, exact for 16-bit ticks
    localparam int          DIST_SHIFT = 24;
    localparam logic [21:0] DIST_MULT  = 22'd2852127;
    localparam int          PROD_W     = 38;
    localparam logic [DIST_W-1:0] DIST_MAX = 14'd11140;

    typedef struct packed {
        cmd_t        command;
        logic [1:0]  key_number;
        logic [7:0]  serial_byte;
        logic [15:0] echo_ticks;
    } item_t;

    typedef struct packed {
        logic              motor_drive;
        logic [1:0]        gear;
        logic [6:0]        segment_code;
        logic              obstacle_led;
        logic [DIST_W-1:0] distance_cm;
    } result_t;

    typedef struct packed {
        logic [7:0]        period_ticks;
        logic [7:0]        gear_one_duty;
        logic [7:0]        gear_two_duty;
        logic [7:0]        gear_three_duty;
        logic [DIST_W-1:0] near_threshold_cm;
    } cfg_t;

    // Common-cathode pattern for the gear digit
    function automatic logic [6:0] seg_code(input logic [1:0] g);
        logic [6:0] s;
        case (g)
            GEAR_STOP: s = 7'h3F;
            GEAR_ONE:  s = 7'h06;
            GEAR_TWO:  s = 7'h5B;
            default:   s = 7'h4F;
        endcase
        return s;
    endfunction

endpackage

// ===== src/gpmc_cfg.sv =====
// Configuration register file for the gear PWM motor controller.
// Depends on gpmc_pkg for register indexes, reset values and cfg_t.
module gpmc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gpmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gpmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output gpmc_pkg::cfg_t                   cfg
);

    gpmc_pkg::cfg_t cfg_reg;
    gpmc_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register; other indexes drop
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                gpmc_pkg::REG_PERIOD_TICKS: cfg_next.period_ticks    = cfg_data[7:0];
                gpmc_pkg::REG_GEAR1_DUTY:   cfg_next.gear_one_duty   = cfg_data[7:0];
                gpmc_pkg::REG_GEAR2_DUTY:   cfg_next.gear_two_duty   = cfg_data[7:0];
                gpmc_pkg::REG_GEAR3_DUTY:   cfg_next.gear_three_duty = cfg_data[7:0];
                gpmc_pkg::REG_NEAR_THRESH:  cfg_next.near_threshold_cm = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ticks      <= gpmc_pkg::RST_PERIOD_TICKS;
            cfg_reg.gear_one_duty     <= gpmc_pkg::RST_GEAR1_DUTY;
            cfg_reg.gear_two_duty     <= gpmc_pkg::RST_GEAR2_DUTY;
            cfg_reg.gear_three_duty   <= gpmc_pkg::RST_GEAR3_DUTY;
            cfg_reg.near_threshold_cm <= gpmc_pkg::RST_NEAR_THRESH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/gpmc_core.sv =====
// Event processing and result register for the gear PWM motor controller.
// Holds PWM, gear and distance state; depends on gpmc_pkg.
module gpmc_core #(
    parameter int ECHO_TIMEOUT = 60000
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gpmc_pkg::cfg_t      cfg,
    input  logic                beat_valid,
    input  gpmc_pkg::item_t     beat,
    output logic                take,
    output logic                result_valid,
    input  logic                result_stall,
    output gpmc_pkg::result_t   result
);

    localparam logic [15:0] TIMEOUT_TICKS = 16'(ECHO_TIMEOUT);
    localparam logic [15:0] LONG_TICKS    = 16'(ECHO_TIMEOUT + 1);

    logic [7:0]                  cnt_reg, cnt_next;
    logic [7:0]                  duty_reg, duty_next;
    logic [1:0]                  gear_reg, gear_next;
    logic                        drive_reg, drive_next;
    logic                        obst_reg, obst_next;
    logic [gpmc_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic                        valid_reg, valid_next;
    gpmc_pkg::result_t           result_reg, result_next;

    logic [7:0]                  cnt_inc;
    logic [15:0]                 ticks;
    logic [gpmc_pkg::PROD_W-1:0] prod;
    logic [gpmc_pkg::DIST_W-1:0] dist_new;
    logic                        sel_en;
    logic [1:0]                  sel_gear;

    // Take a beat when the result register is free or draining
    assign take = beat_valid && (!valid_reg || !result_stall);

    // Distance: clamp long echoes, then multiply by the scaled reciprocal
    always_comb
    begin
        ticks    = (beat.echo_ticks > TIMEOUT_TICKS) ? LONG_TICKS : beat.echo_ticks;
        prod     = gpmc_pkg::PROD_W'(ticks) * gpmc_pkg::PROD_W'(gpmc_pkg::DIST_MULT);
        dist_new = prod[gpmc_pkg::DIST_SHIFT +: gpmc_pkg::DIST_W];
    end

    assign cnt_inc = cnt_reg + 8'd1;

    // Decode the event into state updates and an optional gear selection
    always_comb
    begin
        cnt_next   = cnt_reg;
        drive_next = drive_reg;
        obst_next  = obst_reg;
        dist_next  = dist_reg;
        sel_en     = 1'b0;
        sel_gear   = gpmc_pkg::GEAR_STOP;
        case (beat.command)
            gpmc_pkg::CMD_TICK:
            begin
                drive_next = (cnt_inc <= duty_reg);
                cnt_next   = (cnt_inc >= cfg.period_ticks) ? 8'd0 : cnt_inc;
            end
            gpmc_pkg::CMD_KEY:
            begin
                sel_en   = (beat.key_number != gpmc_pkg::GEAR_STOP);
                sel_gear = beat.key_number;
            end
            gpmc_pkg::CMD_SERIAL:
            begin
                case (beat.serial_byte)
                    gpmc_pkg::BYTE_GEAR1:
                    begin
                        sel_en   = 1'b1;
                        sel_gear = gpmc_pkg::GEAR_ONE;
                    end
                    gpmc_pkg::BYTE_GEAR2:
                    begin
                        sel_en   = 1'b1;
                        sel_gear = gpmc_pkg::GEAR_TWO;
                    end
                    gpmc_pkg::BYTE_GEAR3, gpmc_pkg::BYTE_GEAR3_ALT:
                    begin
                        sel_en   = 1'b1;
                        sel_gear = gpmc_pkg::GEAR_THREE;
                    end
                    gpmc_pkg::BYTE_STOP:
                    begin
                        sel_en   = 1'b1;
                        sel_gear = gpmc_pkg::GEAR_STOP;
                    end
                    default: ;
                endcase
            end
            default:
            begin
                dist_next = dist_new;
                obst_next = (dist_new < cfg.near_threshold_cm);
                sel_en    = obst_next;
                sel_gear  = gpmc_pkg::GEAR_STOP;
            end
        endcase
    end

    // Load the duty of the selected gear
    always_comb
    begin
        gear_next = gear_reg;
        duty_next = duty_reg;
        if (sel_en)
        begin
            gear_next = sel_gear;
            case (sel_gear)
                gpmc_pkg::GEAR_ONE:   duty_next = cfg.gear_one_duty;
                gpmc_pkg::GEAR_TWO:   duty_next = cfg.gear_two_duty;
                gpmc_pkg::GEAR_THREE: duty_next = cfg.gear_three_duty;
                default:              duty_next = 8'd0;
            endcase
        end
    end

    // Build the result beat from the state after the event
    always_comb
    begin
        result_next.motor_drive  = drive_next;
        result_next.gear         = gear_next;
        result_next.segment_code = gpmc_pkg::seg_code(gear_next);
        result_next.obstacle_led = obst_next;
        result_next.distance_cm  = dist_next;
        valid_next = take ? 1'b1 : (valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 8'd0;
            duty_reg  <= 8'd0;
            gear_reg  <= gpmc_pkg::GEAR_STOP;
            drive_reg <= 1'b0;
            obst_reg  <= 1'b0;
            dist_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                cnt_reg   <= cnt_next;
                duty_reg  <= duty_next;
                gear_reg  <= gear_next;
                drive_reg <= drive_next;
                obst_reg  <= obst_next;
                dist_reg  <= dist_next;
            end
        end
    end

    // Hold the result payload while stalled
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== src/gear_pwm_motor_controller.sv =====
// Top level of the gear PWM motor controller.
// Instantiates gpmc_cfg and gpmc_core; depends on gpmc_pkg.
//
// Usage:
//   Input channel (item_valid / item_stall / item) carries one event per beat:
//   a PWM tick, a gear key, a serial command byte or an echo measurement.
//   Output channel (result_valid / result_stall / result) returns one beat per
//   event: drive level, gear, segment pattern, obstacle LED and distance, all
//   taken from the state after that event.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   it only while no event is in flight. Gear duties are copied at gear
//   selection, so a duty write takes effect on the next selection.
//   Path: input register, then one pass of decode, distance multiply and
//   compare into the result register.
//   Throughput: one event per cycle while the result side does not stall.
//   Reset: counter, duty, gear, drive, LED and distance clear; registers take
//   their default values; no beats are pending.
//   A stalled receiver holds the result; one more event waits in the input
//   register, after which item_stall rises.
module gear_pwm_motor_controller #(
    parameter int ECHO_TIMEOUT = 60000
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  gpmc_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output gpmc_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [gpmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gpmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    gpmc_pkg::cfg_t  cfg;
    gpmc_pkg::item_t item_reg;
    logic            item_valid_reg, item_valid_next;
    logic            take;
    logic            item_load;

    gpmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stall only when the input register is full and cannot advance
    assign item_stall = item_valid_reg && !take;
    assign item_load  = item_valid && !item_stall;

    always_comb
    begin
        item_valid_next = item_load ? 1'b1 : (item_valid_reg && !take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            item_reg <= item;
        end
    end

    gpmc_core #(
        .ECHO_TIMEOUT (ECHO_TIMEOUT)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .beat_valid   (item_valid_reg),
        .beat         (item_reg),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // An accepted beat always lands in the input register
    a_item_lands: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_valid_reg)
        else $error("accepted beat lost before input register");

    // A new result appears only after a beat waited in the input register
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid_reg))
        else $error("result beat without an input beat");

    // Segment pattern tracks the reported gear
    a_seg_gear: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.segment_code == gpmc_pkg::seg_code(result.gear))
        else $error("segment pattern does not match gear");

    // Distance never exceeds DIST_MAX, the distance of a full-scale 16-bit echo
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.distance_cm <= gpmc_pkg::DIST_MAX)
        else $error("distance out of range");

endmodule

// ===== dv/gpmc_checker.sv =====
// Checker for the gear PWM motor controller: watches the event, result and
// register-write ports, predicts each result beat and compares field by field.
// Depends on gpmc_pkg for the beat structs, event kinds and register indexes.
module gpmc_checker #(
    parameter int ECHO_LIMIT = 60000
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic                             item_stall,
    input  gpmc_pkg::item_t                  item,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  gpmc_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [gpmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gpmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               pending
);

    // Register copies
    logic [7:0]                  period_r;
    logic [7:0]                  duty1_r;
    logic [7:0]                  duty2_r;
    logic [7:0]                  duty3_r;
    logic [gpmc_pkg::DIST_W-1:0] thresh_r;

    // Motor state copies
    logic [7:0]                  count_r;
    logic [7:0]                  duty_r;
    logic [1:0]                  gear_r;
    logic                        drive_r;
    logic                        near_r;
    logic [gpmc_pkg::DIST_W-1:0] dist_r;

    gpmc_pkg::result_t           motor_expected[$];
    gpmc_pkg::result_t           oldest;
    int                          errors = 0;

    assign fail_count = errors;

    // Digit pattern shown for each gear
    function automatic logic [6:0] digit_pattern(input logic [1:0] g);
        logic [6:0] pat;
        case (g)
            gpmc_pkg::GEAR_STOP:  pat = 7'h3F;
            gpmc_pkg::GEAR_ONE:   pat = 7'h06;
            gpmc_pkg::GEAR_TWO:   pat = 7'h5B;
            default:              pat = 7'h4F;
        endcase
        return pat;
    endfunction

    // Select a gear and capture its duty
    task automatic pick_gear(input logic [1:0] g);
        gear_r = g;
        case (g)
            gpmc_pkg::GEAR_ONE:   duty_r = duty1_r;
            gpmc_pkg::GEAR_TWO:   duty_r = duty2_r;
            gpmc_pkg::GEAR_THREE: duty_r = duty3_r;
            default:              duty_r = '0;
        endcase
    endtask

    // Advance the motor state by one event
    task automatic apply_event(input gpmc_pkg::item_t ev);
        int unsigned ticks;
        case (ev.command)
            gpmc_pkg::CMD_TICK:
            begin
                count_r = count_r + 8'd1;
                drive_r = (count_r <= duty_r);
                if (count_r >= period_r)
                    count_r = '0;
            end
            gpmc_pkg::CMD_KEY:
            begin
                if (ev.key_number != '0)
                    pick_gear(ev.key_number);
            end
            gpmc_pkg::CMD_SERIAL:
            begin
                case (ev.serial_byte)
                    gpmc_pkg::BYTE_GEAR1: pick_gear(gpmc_pkg::GEAR_ONE);
                    gpmc_pkg::BYTE_GEAR2: pick_gear(gpmc_pkg::GEAR_TWO);
                    gpmc_pkg::BYTE_GEAR3, gpmc_pkg::BYTE_GEAR3_ALT:
                        pick_gear(gpmc_pkg::GEAR_THREE);
                    gpmc_pkg::BYTE_STOP:  pick_gear(gpmc_pkg::GEAR_STOP);
                    default:              ;
                endcase
            end
            default:
            begin
                ticks = ev.echo_ticks;
                if (ticks > ECHO_LIMIT)
                    ticks = ECHO_LIMIT + 1;
                dist_r = gpmc_pkg::DIST_W'((ticks * 17) / 100);
                near_r = (dist_r < thresh_r);
                if (near_r)
                    pick_gear(gpmc_pkg::GEAR_STOP);
            end
        endcase
    endtask

    // Report one field that differs
    task automatic flag_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endtask

    // Track register writes, compare result beats, predict from event beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_r = gpmc_pkg::RST_PERIOD_TICKS;
            duty1_r  = gpmc_pkg::RST_GEAR1_DUTY;
            duty2_r  = gpmc_pkg::RST_GEAR2_DUTY;
            duty3_r  = gpmc_pkg::RST_GEAR3_DUTY;
            thresh_r = gpmc_pkg::RST_NEAR_THRESH;
            count_r  = '0;
            duty_r   = '0;
            gear_r   = gpmc_pkg::GEAR_STOP;
            drive_r  = 1'b0;
            near_r   = 1'b0;
            dist_r   = '0;
            motor_expected.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gpmc_pkg::REG_PERIOD_TICKS: period_r = cfg_data[7:0];
                    gpmc_pkg::REG_GEAR1_DUTY:   duty1_r  = cfg_data[7:0];
                    gpmc_pkg::REG_GEAR2_DUTY:   duty2_r  = cfg_data[7:0];
                    gpmc_pkg::REG_GEAR3_DUTY:   duty3_r  = cfg_data[7:0];
                    gpmc_pkg::REG_NEAR_THRESH:  thresh_r = cfg_data;
                    default:                    ;
                endcase
            end

            if (result_valid && !result_stall)
            begin
                if (motor_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with none expected, actual %p", $time, result);
                end
                else
                begin
                    oldest = motor_expected.pop_front();
                    if (result.motor_drive !== oldest.motor_drive)
                        flag_field("motor_drive", oldest.motor_drive, result.motor_drive);
                    if (result.gear !== oldest.gear)
                        flag_field("gear", oldest.gear, result.gear);
                    if (result.segment_code !== oldest.segment_code)
                        flag_field("segment_code", oldest.segment_code, result.segment_code);
                    if (result.obstacle_led !== oldest.obstacle_led)
                        flag_field("obstacle_led", oldest.obstacle_led, result.obstacle_led);
                    if (result.distance_cm !== oldest.distance_cm)
                        flag_field("distance_cm", oldest.distance_cm, result.distance_cm);
                end
            end

            if (item_valid && !item_stall)
            begin
                apply_event(item);
                motor_expected.push_back('{motor_drive:  drive_r,
                                           gear:         gear_r,
                                           segment_code: digit_pattern(gear_r),
                                           obstacle_led: near_r,
                                           distance_cm:  dist_r});
            end

            pending <= motor_expected.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the gear PWM motor controller test: clock, reset, event stimulus,
// register settings and result-side stalls; gpmc_checker does the prediction.
// Depends on gpmc_pkg, gear_pwm_motor_controller and gpmc_checker.
module testbench;

    typedef enum int { FLOW, LIGHT, HEAVY, CHOKE } stall_mode_t;

    logic                             clk;
    logic                             rst_n;
    logic                             item_valid;
    logic                             item_stall;
    gpmc_pkg::item_t                  item;
    logic                             result_valid;
    logic                             result_stall;
    gpmc_pkg::result_t                result;
    logic                             cfg_we;
    logic [gpmc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gpmc_pkg::CFG_DATA_W-1:0]  cfg_data;

    int                               fail_count;
    int                               pending;
    int                               burst_left = 0;
    int                               stall_left = 0;
    stall_mode_t                      stall_mode = FLOW;
    logic [gpmc_pkg::DIST_W-1:0]      near_cm = gpmc_pkg::RST_NEAR_THRESH;

    gear_pwm_motor_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    gpmc_checker motor_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stall the result side in stretches of varying pressure
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(10, 80);
        end
        stall_left--;
        case (stall_mode)
            FLOW:    result_stall <= 1'b0;
            LIGHT:   result_stall <= ($urandom_range(0, 3) == 0);
            HEAVY:   result_stall <= ($urandom_range(0, 1) == 0);
            default: result_stall <= ($urandom_range(0, 15) < 13);
        endcase
    end

    function automatic gpmc_pkg::item_t make_event(input gpmc_pkg::cmd_t c,
                                                   input logic [1:0] k,
                                                   input logic [7:0] b,
                                                   input logic [15:0] e);
        gpmc_pkg::item_t ev;
        ev.command     = c;
        ev.key_number  = k;
        ev.serial_byte = b;
        ev.echo_ticks  = e;
        return ev;
    endfunction

    // Mostly ticks to run the PWM, with gear selections and measurements mixed in
    function automatic gpmc_pkg::item_t random_event();
        gpmc_pkg::item_t ev;
        int              roll;
        int              ticks;
        ev = make_event(gpmc_pkg::CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom),
                        16'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 55)
            ev.command = gpmc_pkg::CMD_TICK;
        else if (roll < 67)
        begin
            ev.command = gpmc_pkg::CMD_KEY;
            if (ev.key_number == '0 && $urandom_range(0, 3) != 0)
                ev.key_number = 2'($urandom_range(1, 3));
        end
        else if (roll < 82)
        begin
            ev.command = gpmc_pkg::CMD_SERIAL;
            if ($urandom_range(0, 2) != 0)
                ev.serial_byte = 8'($urandom_range(gpmc_pkg::BYTE_GEAR3_ALT,
                                                   gpmc_pkg::BYTE_GEAR3));
        end
        else
        begin
            ev.command = gpmc_pkg::CMD_MEASURE;
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    // land close to the stop threshold
                    ticks = (int'(near_cm) * 100) / 17 + $urandom_range(0, 20) - 10;
                    if (ticks < 0)
                        ticks = 0;
                    ev.echo_ticks = 16'(ticks);
                end
                2:       ev.echo_ticks = 16'($urandom_range(0, 60001));
                default: ev.echo_ticks = 16'($urandom_range(59990, 65535));
            endcase
        end
        return ev;
    endfunction

    // Present one beat, hold it until taken, then maybe idle between bursts
    task automatic send_event(input gpmc_pkg::item_t ev);
        int gap;
        item       <= ev;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic put_reg(input logic [gpmc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [gpmc_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [7:0] per, input logic [7:0] d1,
                                 input logic [7:0] d2, input logic [7:0] d3,
                                 input logic [gpmc_pkg::DIST_W-1:0] thr);
        put_reg(gpmc_pkg::REG_PERIOD_TICKS, gpmc_pkg::CFG_DATA_W'(per));
        put_reg(gpmc_pkg::REG_GEAR1_DUTY, gpmc_pkg::CFG_DATA_W'(d1));
        put_reg(gpmc_pkg::REG_GEAR2_DUTY, gpmc_pkg::CFG_DATA_W'(d2));
        put_reg(gpmc_pkg::REG_GEAR3_DUTY, gpmc_pkg::CFG_DATA_W'(d3));
        put_reg(gpmc_pkg::REG_NEAR_THRESH, thr);
        cfg_we  <= 1'b0;
        near_cm = thr;
    endtask

    // Drop valid and wait for every expected beat, then let the pipe settle
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every event kind, every command byte, distance extremes
        send_event(make_event(gpmc_pkg::CMD_TICK,    2'd0, 8'h00, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_KEY,     2'd1, 8'h00, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_TICK,    2'd0, 8'h00, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_TICK,    2'd0, 8'h00, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_KEY,     2'd2, 8'h00, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_KEY,     2'd3, 8'h00, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_KEY,     2'd0, 8'h00, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_SERIAL,  2'd0, gpmc_pkg::BYTE_GEAR1, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_SERIAL,  2'd0, gpmc_pkg::BYTE_GEAR2, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_SERIAL,  2'd0, gpmc_pkg::BYTE_GEAR3, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_SERIAL,  2'd0, gpmc_pkg::BYTE_GEAR3_ALT,
                              16'h0000));
        send_event(make_event(gpmc_pkg::CMD_SERIAL,  2'd0, gpmc_pkg::BYTE_STOP, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_SERIAL,  2'd0, 8'h00, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_SERIAL,  2'd0, 8'hFF, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_KEY,     2'd3, 8'h00, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_TICK,    2'd0, 8'h00, 16'h0000));
        send_event(make_event(gpmc_pkg::CMD_MEASURE, 2'd0, 8'h00, 16'd0));
        send_event(make_event(gpmc_pkg::CMD_MEASURE, 2'd0, 8'h00, 16'd12));
        send_event(make_event(gpmc_pkg::CMD_MEASURE, 2'd0, 8'h00, 16'd60000));
        send_event(make_event(gpmc_pkg::CMD_MEASURE, 2'd0, 8'h00, 16'd60001));
        send_event(make_event(gpmc_pkg::CMD_MEASURE, 2'd0, 8'h00, 16'hFFFF));
        send_event(make_event(gpmc_pkg::CMD_MEASURE, 2'd0, 8'h00, 16'd11));
        drain();

        // Random phases, each under its own register settings
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: load_settings(8'd1, 8'd0, 8'd255, 8'd1, 14'd0);
                1: load_settings(8'd255, 8'd255, 8'd0, 8'd128, 14'd10200);
                2: load_settings(8'd10, 8'd3, 8'd7, 8'd10, 14'd50);
                3: load_settings(8'($urandom_range(1, 40)), 8'($urandom_range(0, 45)),
                                 8'($urandom_range(0, 45)), 8'($urandom_range(0, 45)),
                                 14'($urandom_range(0, 10200)));
                default: load_settings(8'd200, 8'd100, 8'd199, 8'd200, 14'd5000);
            endcase
            for (int n = 0; n < 250; n++)
                send_event(random_event());
            drain();
        end

        if (fail_count == 0)
            $display("gear_pwm_motor_controller test passed");
        else
            $display("gear_pwm_motor_controller test failed");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #2000000;
        $display("gear_pwm_motor_controller test failed");
        $finish;
    end

endmodule

// ===== gear_pwm_motor_controller.f =====
src/gpmc_pkg.sv
src/gpmc_cfg.sv
src/gpmc_core.sv
src/gear_pwm_motor_controller.sv
dv/gpmc_checker.sv
dv/testbench.sv
